@@ rtl/core/fc_pkg.sv @@
// Shared types and constants of the fully connected layer.
package fc_pkg;

    localparam int KIND_W      = 2;
    localparam int ROW_W       = 4;
    localparam int COL_W       = 10;
    localparam int VAL_W       = 16;
    localparam int PROD_W      = 32;
    localparam int ACC_W       = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int IN_CNT_W    = 11;
    localparam int OUT_CNT_W   = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic                 RELU_RESET      = 1'b1;
    localparam logic [IN_CNT_W-1:0]  IN_COUNT_RESET  = 11'd784;
    localparam logic [OUT_CNT_W-1:0] OUT_COUNT_RESET = 5'd16;

    typedef enum logic [KIND_W-1:0] {
        KIND_WEIGHT  = 2'd0,
        KIND_BIAS    = 2'd1,
        KIND_FEATURE = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RELU      = 2'd0,
        CFG_IN_COUNT  = 2'd1,
        CFG_OUT_COUNT = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_SUM,
        ST_EMIT_OUT
    } t_back_state;

    typedef struct packed {
        logic                 relu_enable;
        logic [IN_CNT_W-1:0]  in_count;
        logic [OUT_CNT_W-1:0] out_count;
    } t_cfg;

    typedef struct packed {
        t_kind                    kind;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic signed [VAL_W-1:0]  value;
    } t_op;

endpackage

@@ rtl/core/fc_ram.sv @@
// Generic single-port RAM with registered read data.
module fc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/fc_front.sv @@
// Input side: accepts words, drops unused kinds and loads outside the stores.
module fc_front #(
    parameter int MAX_IN  = 1024,
    parameter int MAX_OUT = 16
) (
    input  logic                        i_valid,
    input  logic [fc_pkg::KIND_W-1:0]   i_kind,
    input  logic [fc_pkg::COL_W-1:0]    i_in_index,
    input  logic [fc_pkg::ROW_W-1:0]    i_out_index,
    input  logic signed [fc_pkg::VAL_W-1:0] i_value,
    input  logic                        i_full,
    output logic                        o_stall,
    output logic                        o_push,
    output fc_pkg::t_op                 o_op
);
    import fc_pkg::*;

    t_kind kind;
    logic  row_ok;
    logic  col_ok;
    logic  keep;

    assign kind   = t_kind'(i_kind);
    assign row_ok = 32'(i_out_index) < MAX_OUT;
    assign col_ok = 32'(i_in_index) < MAX_IN;

    always_comb begin
        keep = 1'b0;
        unique case (kind)
            KIND_WEIGHT:  keep = row_ok && col_ok;
            KIND_BIAS:    keep = row_ok;
            KIND_FEATURE: keep = 1'b1;
            default:      keep = 1'b0;
        endcase
    end

    assign o_stall    = i_full;
    assign o_push     = i_valid && !i_full && keep;
    assign o_op.kind  = kind;
    assign o_op.row   = i_out_index;
    assign o_op.col   = i_in_index;
    assign o_op.value = i_value;

endmodule

@@ rtl/core/fc_queue.sv @@
// Two-entry queue of classified operations between the front and the engine.
module fc_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  fc_pkg::t_op i_op,
    output logic        o_full,
    input  logic        i_pop,
    output logic        o_valid,
    output fc_pkg::t_op o_op
);
    import fc_pkg::*;

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_full  = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_op    = r_mem[r_rd];

endmodule

@@ rtl/core/fc_back.sv @@
// Engine: store loads, the shared multiply-accumulate pass and the result pass.
module fc_back #(
    parameter int MAX_IN  = 1024,
    parameter int MAX_OUT = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fc_pkg::t_cfg                    i_cfg,
    input  logic                            i_op_valid,
    input  fc_pkg::t_op                     i_op,
    output logic                            o_op_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [fc_pkg::ROW_W-1:0]        o_neuron,
    output logic signed [fc_pkg::VAL_W-1:0] o_activation,
    output logic                            o_last
);
    import fc_pkg::*;

    localparam int KW     = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int KCW    = $clog2(MAX_OUT + 1);
    localparam int CW     = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
    localparam int FCW    = $clog2(MAX_IN + 1);
    localparam int WA_W   = KW + CW;
    localparam int WDEPTH = 2 ** WA_W;
    localparam int BDEPTH = 2 ** KW;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] x);
        logic signed [ACC_W-1:0] r;
        if (x[ACC_W] != x[ACC_W-1]) begin
            r = x[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            r = x[ACC_W-1:0];
        end
        return r;
    endfunction

    t_back_state r_state;
    t_back_state n_state;

    logic [KW-1:0]              r_k;
    logic [CW-1:0]              r_col;
    logic signed [VAL_W-1:0]    r_v;
    logic [FCW-1:0]             r_fc;
    logic                       r_done;
    logic                       r_p1_vld;
    logic                       r_p1_act;
    logic                       r_p2_vld;
    logic                       r_p2_act;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc [MAX_OUT];
    logic signed [ACC_W-1:0]    r_sum;
    logic                       r_out_valid;
    logic [ROW_W-1:0]           r_out_neuron;
    logic signed [VAL_W-1:0]    r_out_act;
    logic                       r_out_last;

    logic [FCW-1:0]             eff_in;
    logic [KCW-1:0]             nout;
    logic [FCW-1:0]             fc_next;
    logic                       done_now;
    logic                       k_last;
    logic                       k_act;
    logic                       k_is_last_out;
    logic                       out_free;
    logic                       out_load;
    logic                       is_idle;
    logic                       w_we;
    logic [WA_W-1:0]            w_addr;
    logic [VAL_W-1:0]           w_rdata;
    logic                       b_we;
    logic [KW-1:0]              b_addr;
    logic [VAL_W-1:0]           b_rdata;
    logic                       rot;
    logic signed [ACC_W-1:0]    rot_in;
    logic signed [ACC_W:0]      mac_sum;
    logic signed [ACC_W:0]      bias_sum;
    logic signed [ACC_W:0]      rnd;
    logic signed [ACC_W-8:0]    q;
    logic signed [VAL_W-1:0]    act;

    always_comb begin
        if (i_cfg.in_count == '0) begin
            eff_in = FCW'(1);
        end else if (32'(i_cfg.in_count) > MAX_IN) begin
            eff_in = FCW'(MAX_IN);
        end else begin
            eff_in = FCW'(i_cfg.in_count);
        end
        if (i_cfg.out_count == '0) begin
            nout = KCW'(1);
        end else if (32'(i_cfg.out_count) > MAX_OUT) begin
            nout = KCW'(MAX_OUT);
        end else begin
            nout = KCW'(i_cfg.out_count);
        end
    end

    assign fc_next       = r_fc + FCW'(1);
    assign done_now      = fc_next >= eff_in;
    assign k_last        = 32'(r_k) == (MAX_OUT - 1);
    assign k_act         = KCW'(r_k) < nout;
    assign k_is_last_out = (KCW'(r_k) + KCW'(1)) == nout;
    assign out_free      = !r_out_valid || !i_out_stall;
    assign out_load      = (r_state == ST_EMIT_OUT) && k_act && out_free;
    assign is_idle       = r_state == ST_IDLE;

    assign o_op_pop = is_idle && i_op_valid;
    assign w_we     = o_op_pop && (i_op.kind == KIND_WEIGHT);
    assign b_we     = o_op_pop && (i_op.kind == KIND_BIAS);
    assign w_addr   = w_we ? {KW'(i_op.row), CW'(i_op.col)} : {r_k, r_col};
    assign b_addr   = b_we ? KW'(i_op.row) : r_k;

    fc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (WDEPTH)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (i_op.value),
        .o_rdata (w_rdata)
    );

    fc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (BDEPTH)
    ) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_addr  (b_addr),
        .i_wdata (i_op.value),
        .o_rdata (b_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_op_valid && (i_op.kind == KIND_FEATURE)) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (k_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_p1_vld && !r_p2_vld) begin
                    n_state = r_done ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_EMIT_RD:  n_state = ST_EMIT_SUM;
            ST_EMIT_SUM: n_state = ST_EMIT_OUT;
            ST_EMIT_OUT: begin
                if (!k_act || out_free) begin
                    n_state = k_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The accumulators form a ring: the head is the row now being worked on.
    assign mac_sum  = {r_acc[0][ACC_W-1], r_acc[0]}
                    + {{(ACC_W + 1 - PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign bias_sum = {r_acc[0][ACC_W-1], r_acc[0]}
                    + {{(ACC_W + 1 - VAL_W - 8){b_rdata[VAL_W-1]}}, b_rdata, 8'b0};

    always_comb begin
        rot    = 1'b0;
        rot_in = '0;
        if (r_p2_vld) begin
            rot    = 1'b1;
            rot_in = r_p2_act ? sat_acc(mac_sum) : r_acc[0];
        end else if (r_state == ST_EMIT_SUM) begin
            rot    = 1'b1;
            rot_in = '0;
        end
    end

    assign rnd = {r_sum[ACC_W-1], r_sum} + (ACC_W + 1)'(128);
    assign q   = rnd[ACC_W:8];

    always_comb begin
        if (i_cfg.relu_enable && (r_sum[ACC_W-1] || (r_sum == '0))) begin
            act = '0;
        end else if (q[ACC_W-8:VAL_W-1] == {(ACC_W - VAL_W - 6){q[ACC_W-8]}}) begin
            act = q[VAL_W-1:0];
        end else begin
            act = q[ACC_W-8] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_fc        <= '0;
            r_done      <= 1'b0;
            r_p1_vld    <= 1'b0;
            r_p2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_OUT; i++) begin
                r_acc[i] <= '0;
            end
        end else begin
            r_p1_vld <= r_state == ST_MAC;
            r_p2_vld <= r_p1_vld;
            if (is_idle && i_op_valid && (i_op.kind == KIND_FEATURE)) begin
                r_done <= done_now;
                r_fc   <= done_now ? '0 : fc_next;
            end
            if ((r_state == ST_MAC)
                || ((r_state == ST_EMIT_OUT) && (!k_act || out_free))) begin
                r_k <= k_last ? '0 : r_k + 1'b1;
            end
            if (rot) begin
                for (int i = 0; i < MAX_OUT - 1; i++) begin
                    r_acc[i] <= r_acc[i + 1];
                end
                r_acc[MAX_OUT - 1] <= rot_in;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_idle && i_op_valid && (i_op.kind == KIND_FEATURE)) begin
            r_v   <= i_op.value;
            r_col <= r_fc[CW-1:0];
        end
        r_p1_act <= k_act;
        r_p2_act <= r_p1_act;
        r_prod   <= $signed(r_v) * $signed(w_rdata);
        if (r_state == ST_EMIT_SUM) begin
            r_sum <= sat_acc(bias_sum);
        end
        if (out_load) begin
            r_out_neuron <= ROW_W'(r_k);
            r_out_act    <= act;
            r_out_last   <= k_is_last_out;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_neuron     = r_out_neuron;
    assign o_activation = r_out_act;
    assign o_last       = r_out_last;

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_p1_vld && !r_p2_vld))
        else $error("multiply pipeline busy while the engine is idle");

    a_prod_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_vld |-> ((r_state == ST_MAC) || (r_state == ST_DRAIN)))
        else $error("product arrives outside the accumulate pass");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fc) < MAX_IN)
        else $error("feature count has reached the column range");

    a_emit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_SUM) |-> ($past(r_state) == ST_EMIT_RD))
        else $error("bias sum formed without a bias read");

endmodule

@@ rtl/core/dense_layer_relu_mac.sv @@
// Top level of the fully connected layer with optional ReLU.
//
// Input channel: each word carries a kind with row, column and a Q8.8 value.
// Weight and bias words load the stores; feature words are multiplied by
// column feature_count of rows below out_count and added into the 40-bit
// accumulators. A two-entry queue lies between the input side and the engine.
// Loads are written while the engine is idle. For each feature one shared
// 16 x 16 multiplier steps through the rows, one weight memory read per
// cycle, then drains its two-stage pipeline.
// After in_count features the engine reads the bias, sums and outputs each
// row, sending out_count result words (neuron, activation, last) in order.
// The result register holds its word while the receiver stalls, and the
// result pass waits on it; the input side keeps accepting until the queue
// is full. Reset clears the accumulators, the feature count and the
// configuration to ReLU on, 784 inputs and 16 outputs; the stores keep their
// contents and must be loaded before use. Configuration is written through
// the plain write port while idle: a user rule the block does not enforce.
module dense_layer_relu_mac #(
    parameter int MAX_IN  = 1024,
    parameter int MAX_OUT = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [fc_pkg::KIND_W-1:0]           i_kind,
    input  logic [fc_pkg::COL_W-1:0]            i_in_index,
    input  logic [fc_pkg::ROW_W-1:0]            i_out_index,
    input  logic signed [fc_pkg::VAL_W-1:0]     i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [fc_pkg::ROW_W-1:0]            o_neuron,
    output logic signed [fc_pkg::VAL_W-1:0]     o_activation,
    output logic                                o_last,
    input  logic                                i_cfg_we,
    input  logic [fc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [fc_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);
    import fc_pkg::*;

    t_cfg r_cfg;
    logic q_full;
    logic q_push;
    t_op  push_op;
    logic q_pop;
    logic q_valid;
    t_op  q_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.relu_enable <= RELU_RESET;
            r_cfg.in_count    <= IN_COUNT_RESET;
            r_cfg.out_count   <= OUT_COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RELU:      r_cfg.relu_enable <= i_cfg_wdata[0];
                CFG_IN_COUNT:  r_cfg.in_count    <= i_cfg_wdata[IN_CNT_W-1:0];
                CFG_OUT_COUNT: r_cfg.out_count   <= i_cfg_wdata[OUT_CNT_W-1:0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    fc_front #(
        .MAX_IN  (MAX_IN),
        .MAX_OUT (MAX_OUT)
    ) u_front (
        .i_valid     (i_in_valid),
        .i_kind      (i_kind),
        .i_in_index  (i_in_index),
        .i_out_index (i_out_index),
        .i_value     (i_value),
        .i_full      (q_full),
        .o_stall     (o_in_stall),
        .o_push      (q_push),
        .o_op        (push_op)
    );

    fc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (push_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    fc_back #(
        .MAX_IN  (MAX_IN),
        .MAX_OUT (MAX_OUT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_op_valid   (q_valid),
        .i_op         (q_op),
        .o_op_pop     (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_neuron     (o_neuron),
        .o_activation (o_activation),
        .o_last       (o_last)
    );

endmodule
